### sv/spc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the shutter position controller.
// No dependencies; every other file of the block imports this package.
package spc_pkg;

    // Highest known level: 0 is fully open, FULL_LEVEL is fully closed.
    localparam int FULL_LEVEL = 100;

    localparam logic [6:0] LVL_FULL    = 7'(FULL_LEVEL);
    localparam logic [6:0] LVL_UNKNOWN = 7'(FULL_LEVEL + 1);
    localparam logic [7:0] LVL_IN_FULL = 8'(FULL_LEVEL);

    localparam logic [23:0] MAX24 = 24'hFF_FFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    // Phase codes.
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HOMING = 3'd1;
    localparam logic [2:0] PH_CALIB  = 3'd2;
    localparam logic [2:0] PH_TARGET = 3'd3;
    localparam logic [2:0] PH_NORMAL = 3'd4;

    // Relay command codes.
    localparam logic [1:0] RELAY_NONE = 2'd0;
    localparam logic [1:0] RELAY_UP   = 2'd1;
    localparam logic [1:0] RELAY_DOWN = 2'd2;
    localparam logic [1:0] RELAY_HALT = 2'd3;

    // Operation codes of an input word.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;
    localparam logic [1:0] OP_LOAD = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_COURSE = 2'd0;
    localparam logic [1:0] REG_CALIB  = 2'd1;
    localparam logic [1:0] REG_STEP   = 2'd2;
    localparam logic [1:0] REG_SAFETY = 2'd3;

    typedef struct packed {
        logic [23:0] course_time;
        logic [23:0] calibration_time;
        logic [23:0] step_time;
        logic [15:0] rest_time;
    } spc_cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic        moving_down;
        logic [6:0]  position;
        logic [6:0]  target;
        logic        safety_active;
        logic [15:0] safety_elapsed;
        logic [23:0] phase_elapsed;
    } spc_state_t;

    typedef struct packed {
        logic [1:0] relay_command;
        logic       save_strobe;
        logic [6:0] saved_level;
    } spc_result_t;

endpackage

### sv/shutter_position_controller_core.sv
`timescale 1ns / 1ps
// Top level of the time-based shutter position controller.
// Depends on spc_pkg, spc_regs (configuration port) and spc_step (per-word logic).

// The controller takes one input word per clock cycle while in_ready is high and returns exactly one result
// word for each: a word is processed in the cycle it is accepted, the controller state
// registers update at that edge, and the result lands in an output register on the
// next cycle. in_ready stays high while that output register is empty or being drained,
// so a stalled consumer only holds the input back once a result is actually waiting.
// Time advances one millisecond per tick word (op 0); set-level (op 1), stop (op 2) and
// load-stored-level (op 3) words change the target or position and return relay
// command none. An unknown position is resolved by driving up for course plus
// calibration time; each level step takes step_time ticks, reaching an end stop adds a
// calibration overrun, and every halt is followed by a relay rest of rest_time ticks.
// Registers sit on the APB-style port at byte addresses 0 (course_time), 4
// (calibration_time), 8 (step_time) and 12 (rest_time); write them only while the
// controller is idle with no result outstanding.
module shutter_position_controller_core (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  level_value,
    // Output channel.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  relay_command,
    output logic        save_strobe,
    output logic [6:0]  saved_level,
    output logic        is_idle,
    output logic [6:0]  current_level
);
    import spc_pkg::*;

    spc_cfg_t    cfg;
    spc_state_t  state_reg;
    spc_state_t  state_next;
    spc_result_t step_res;
    logic        in_fire;

    // Output register; the payload needs no reset.
    logic        out_valid_reg;
    spc_result_t res_reg;
    logic        idle_reg;
    logic [6:0]  level_reg;

    spc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spc_step u_step (
        .cfg         (cfg),
        .cur         (state_reg),
        .op          (op),
        .level_value (level_value),
        .nxt         (state_next),
        .res         (step_res)
    );

    // A new word may enter whenever the output register is free or emptying this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase          <= PH_IDLE;
            state_reg.moving_down    <= 1'b0;
            state_reg.position       <= LVL_UNKNOWN;
            state_reg.target         <= LVL_UNKNOWN;
            state_reg.safety_active  <= 1'b0;
            state_reg.safety_elapsed <= 16'd0;
            state_reg.phase_elapsed  <= 24'd0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg   <= step_res;
            idle_reg  <= (state_next.phase == PH_IDLE);
            level_reg <= state_next.position;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_command = res_reg.relay_command;
    assign save_strobe   = res_reg.save_strobe;
    assign saved_level   = res_reg.saved_level;
    assign is_idle       = idle_reg;
    assign current_level = level_reg;

endmodule

### sv/spc_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the shutter position controller on an APB-style port.
// Depends on spc_pkg for the register indexes and the configuration struct.
module spc_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output spc_pkg::spc_cfg_t cfg
);
    import spc_pkg::*;

    spc_cfg_t   cfg_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.course_time      <= 24'd30000;
            cfg_reg.calibration_time <= 24'd3000;
            cfg_reg.step_time        <= 24'd300;
            cfg_reg.rest_time        <= 16'd1000;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_COURSE: cfg_reg.course_time      <= pwdata[23:0];
                REG_CALIB:  cfg_reg.calibration_time <= pwdata[23:0];
                REG_STEP:   cfg_reg.step_time        <= pwdata[23:0];
                REG_SAFETY: cfg_reg.rest_time        <= pwdata[15:0];
                default:    cfg_reg.rest_time        <= cfg_reg.rest_time;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_COURSE: prdata = {8'd0, cfg_reg.course_time};
            REG_CALIB:  prdata = {8'd0, cfg_reg.calibration_time};
            REG_STEP:   prdata = {8'd0, cfg_reg.step_time};
            REG_SAFETY: prdata = {16'd0, cfg_reg.rest_time};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

### sv/spc_step.sv
`timescale 1ns / 1ps
// Next-state and result logic of the shutter position controller for one input word.
// Depends on spc_pkg for codes, constants and the state, config and result structs.
module spc_step (
    input  spc_pkg::spc_cfg_t    cfg,
    input  spc_pkg::spc_state_t  cur,
    input  logic [1:0]           op,
    input  logic [7:0]           level_value,
    output spc_pkg::spc_state_t  nxt,
    output spc_pkg::spc_result_t res
);
    import spc_pkg::*;

    logic [15:0] se_inc;
    logic [23:0] pe_inc;
    logic [24:0] homing_sum;
    logic [23:0] homing_time;
    logic [6:0]  stepped_pos;
    logic        leaves_range;
    logic        set_down;

    assign se_inc      = (cur.safety_elapsed < MAX16) ? cur.safety_elapsed + 16'd1
                                                      : cur.safety_elapsed;
    assign pe_inc      = (cur.phase_elapsed < MAX24) ? cur.phase_elapsed + 24'd1
                                                     : cur.phase_elapsed;
    assign homing_sum  = {1'b0, cfg.course_time} + {1'b0, cfg.calibration_time};
    assign homing_time = homing_sum[24] ? MAX24 : homing_sum[23:0];
    assign stepped_pos = cur.moving_down ? cur.position + 7'd1 : cur.position - 7'd1;
    assign leaves_range = (!cur.moving_down && cur.position == 7'd0) ||
                          (cur.moving_down && cur.position >= LVL_FULL);
    assign set_down    = level_value > {1'b0, cur.position};

    always_comb
    begin
        nxt = cur;
        res = '{relay_command: RELAY_NONE, save_strobe: 1'b0, saved_level: 7'd0};

        case (op)
            OP_TICK:
            begin
                nxt.safety_elapsed = se_inc;
                nxt.phase_elapsed  = pe_inc;
                if (cur.safety_active)
                begin
                    if (se_inc >= cfg.rest_time)
                        nxt.safety_active = 1'b0;
                end
                else if (cur.position == LVL_UNKNOWN)
                begin
                    if (cur.phase != PH_HOMING)
                    begin
                        res.relay_command = RELAY_UP;
                        nxt.phase         = PH_HOMING;
                        nxt.phase_elapsed = 24'd0;
                    end
                    else if (pe_inc >= homing_time)
                    begin
                        res.relay_command  = RELAY_HALT;
                        nxt.safety_active  = 1'b1;
                        nxt.safety_elapsed = 16'd0;
                        nxt.phase          = PH_IDLE;
                        nxt.position       = 7'd0;
                        res.save_strobe    = 1'b1;
                        res.saved_level    = 7'd0;
                    end
                end
                else if (cur.phase == PH_IDLE && cur.target == LVL_UNKNOWN)
                begin
                    nxt.phase_elapsed = pe_inc;
                end
                else if (cur.phase == PH_CALIB)
                begin
                    if (pe_inc >= cfg.calibration_time)
                    begin
                        res.relay_command  = RELAY_HALT;
                        nxt.safety_active  = 1'b1;
                        nxt.safety_elapsed = 16'd0;
                        nxt.phase          = PH_IDLE;
                        res.save_strobe    = 1'b1;
                        res.saved_level    = cur.position;
                    end
                end
                else if (cur.phase == PH_IDLE)
                begin
                    // Starting a move: the stored level is no longer trustworthy.
                    res.save_strobe   = 1'b1;
                    res.saved_level   = LVL_UNKNOWN;
                    nxt.moving_down   = cur.target > cur.position;
                    res.relay_command = (cur.target > cur.position) ? RELAY_DOWN : RELAY_UP;
                    nxt.phase         = PH_TARGET;
                    nxt.phase_elapsed = 24'd0;
                end
                else if (pe_inc >= cfg.step_time)
                begin
                    nxt.phase_elapsed = 24'd0;
                    if (leaves_range)
                    begin
                        nxt.position       = LVL_UNKNOWN;
                        res.relay_command  = RELAY_HALT;
                        nxt.safety_active  = 1'b1;
                        nxt.safety_elapsed = 16'd0;
                        nxt.phase          = PH_IDLE;
                        nxt.target         = LVL_UNKNOWN;
                        res.save_strobe    = 1'b1;
                        res.saved_level    = LVL_UNKNOWN;
                    end
                    else
                    begin
                        nxt.position = stepped_pos;
                        if (stepped_pos == 7'd0 || stepped_pos == LVL_FULL)
                        begin
                            nxt.phase = PH_CALIB;
                            if (stepped_pos == cur.target)
                                nxt.target = LVL_UNKNOWN;
                        end
                        else if (cur.phase == PH_NORMAL)
                        begin
                            res.relay_command  = RELAY_HALT;
                            nxt.safety_active  = 1'b1;
                            nxt.safety_elapsed = 16'd0;
                            nxt.phase          = PH_IDLE;
                            if (cur.target == LVL_UNKNOWN)
                            begin
                                res.save_strobe = 1'b1;
                                res.saved_level = stepped_pos;
                            end
                        end
                        else if (cur.phase == PH_TARGET && stepped_pos == cur.target)
                        begin
                            res.relay_command  = RELAY_HALT;
                            nxt.safety_active  = 1'b1;
                            nxt.safety_elapsed = 16'd0;
                            nxt.phase          = PH_IDLE;
                            nxt.target         = LVL_UNKNOWN;
                            res.save_strobe    = 1'b1;
                            res.saved_level    = stepped_pos;
                        end
                    end
                end
            end
            OP_SET:
            begin
                if (level_value <= LVL_IN_FULL &&
                    !(cur.phase == PH_IDLE && level_value[6:0] == cur.position) &&
                    !((cur.phase == PH_TARGET || cur.phase == PH_NORMAL) &&
                      level_value[6:0] == cur.target))
                begin
                    nxt.target = level_value[6:0];
                    if (cur.phase == PH_TARGET && set_down != cur.moving_down)
                        nxt.phase = PH_NORMAL;
                end
            end
            OP_STOP:
            begin
                if (cur.phase != PH_IDLE)
                begin
                    nxt.target = LVL_UNKNOWN;
                    if (cur.phase == PH_TARGET)
                        nxt.phase = PH_NORMAL;
                end
            end
            OP_LOAD:
            begin
                nxt.position = (level_value > LVL_IN_FULL) ? LVL_UNKNOWN : level_value[6:0];
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule
